/* rtl/core/qet_pkg.sv */
package qet_pkg;

    localparam int TOKEN_CAP_DEFAULT        = 1023;
    localparam int MAX_TOKENS_LIMIT_DEFAULT = 255;
    localparam logic [7:0] MAX_TOKENS_RESET = 8'd64;

    // results one input byte can cause at most
    localparam int RUN_SLOTS   = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic ERR_TOO_MANY   = 1'b0;
    localparam logic ERR_OPEN_QUOTE = 1'b1;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] token_byte;
        logic [7:0] token_number;
        logic       error_code;
    } t_result;

    typedef struct packed {
        logic [1:0]                    count;
        t_result [RUN_SLOTS-1:0]       res;
    } t_run;

endpackage

/* rtl/core/qet_front.sv */
module qet_front #(
    parameter int TOKEN_CAP        = qet_pkg::TOKEN_CAP_DEFAULT,
    parameter int MAX_TOKENS_LIMIT = qet_pkg::MAX_TOKENS_LIMIT_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_ch,
    input  logic          i_is_end,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_q_full,
    output logic          o_push,
    output qet_pkg::t_run o_run
);

    localparam int LEN_W = $clog2(TOKEN_CAP + 1);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(TOKEN_CAP - 1);
    localparam logic [16:0] LIMIT_CAP = 17'(MAX_TOKENS_LIMIT);

    typedef enum logic [2:0] {
        MODE_BETWEEN,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_MUST_CLOSE,
        MODE_DISCARD
    } t_mode;

    t_mode            r_mode, n_mode;
    logic             r_qd, n_qd;
    logic             r_esc, n_esc;
    logic [LEN_W-1:0] r_len, n_len;
    logic [7:0]       r_count, n_count;
    logic [7:0]       r_max_tokens;

    logic             w_accept;
    logic             w_space;
    logic             w_quote;
    logic [7:0]       w_close_ch;
    logic [16:0]      w_cfg_ext;
    logic [16:0]      w_limit;
    logic             w_limit_hit;
    logic [LEN_W-1:0] w_len_base;
    logic             w_cap_reach;

    logic             e_append;
    logic [7:0]       e_byte;
    logic             e_plain_ctx;
    logic             e_finish;
    logic             e_fail;
    logic             e_code;
    logic             e_done;
    qet_pkg::t_run    w_run;

    assign o_ready     = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;

    assign w_space     = (i_ch == qet_pkg::CH_SPACE) ||
                         (i_ch inside {[qet_pkg::CH_TAB:qet_pkg::CH_CR]});
    assign w_quote     = (i_ch == qet_pkg::CH_DQUOTE) || (i_ch == qet_pkg::CH_SQUOTE);
    assign w_close_ch  = r_qd ? qet_pkg::CH_DQUOTE : qet_pkg::CH_SQUOTE;

    assign w_cfg_ext   = {9'd0, r_max_tokens};
    assign w_limit     = (w_cfg_ext > LIMIT_CAP) ? LIMIT_CAP : w_cfg_ext;
    assign w_limit_hit = ({9'd0, r_count} >= w_limit);

    // a token started by this byte counts from zero
    assign w_len_base  = (r_mode == MODE_BETWEEN) ? '0 : r_len;
    assign w_cap_reach = (w_len_base == LEN_LAST);

    always_comb begin
        logic [1:0] k;
        n_mode      = r_mode;
        n_qd        = r_qd;
        n_esc       = r_esc;
        n_len       = r_len;
        n_count     = r_count;
        e_append    = 1'b0;
        e_byte      = i_ch;
        e_plain_ctx = 1'b0;
        e_finish    = 1'b0;
        e_fail      = 1'b0;
        e_code      = qet_pkg::ERR_TOO_MANY;
        e_done      = 1'b0;
        w_run       = '0;
        k           = 2'd0;

        if (i_is_end) begin
            case (r_mode)
                MODE_BETWEEN: begin
                    e_done = 1'b1;
                end
                MODE_PLAIN: begin
                    // trailing backslash stays literal
                    e_append    = r_esc;
                    e_byte      = qet_pkg::CH_BACKSLASH;
                    e_plain_ctx = 1'b1;
                    e_finish    = 1'b1;
                    e_done      = 1'b1;
                end
                MODE_QUOTED: begin
                    e_append = r_esc;
                    e_byte   = qet_pkg::CH_BACKSLASH;
                    e_fail   = 1'b1;
                    e_code   = qet_pkg::ERR_OPEN_QUOTE;
                end
                MODE_MUST_CLOSE: begin
                    e_fail = 1'b1;
                    e_code = qet_pkg::ERR_OPEN_QUOTE;
                end
                default: begin
                end
            endcase
        end else begin
            case (r_mode)
                MODE_BETWEEN: begin
                    if (!w_space) begin
                        if (w_limit_hit) begin
                            e_fail = 1'b1;
                            e_code = qet_pkg::ERR_TOO_MANY;
                        end else if (w_quote) begin
                            n_mode = MODE_QUOTED;
                            n_qd   = (i_ch == qet_pkg::CH_DQUOTE);
                            n_len  = '0;
                            n_esc  = 1'b0;
                        end else begin
                            n_mode = MODE_PLAIN;
                            n_len  = '0;
                            if (i_ch == qet_pkg::CH_BACKSLASH) begin
                                n_esc = 1'b1;
                            end else begin
                                n_esc       = 1'b0;
                                e_append    = 1'b1;
                                e_plain_ctx = 1'b1;
                            end
                        end
                    end
                end
                MODE_PLAIN: begin
                    e_plain_ctx = 1'b1;
                    if (r_esc) begin
                        n_esc    = 1'b0;
                        e_append = 1'b1;
                    end else if (w_space) begin
                        e_finish = 1'b1;
                    end else if (i_ch == qet_pkg::CH_BACKSLASH) begin
                        n_esc = 1'b1;
                    end else begin
                        e_append = 1'b1;
                    end
                end
                MODE_QUOTED: begin
                    if (r_esc) begin
                        n_esc    = 1'b0;
                        e_append = 1'b1;
                    end else if (i_ch == w_close_ch) begin
                        e_finish = 1'b1;
                    end else if (i_ch == qet_pkg::CH_BACKSLASH) begin
                        n_esc = 1'b1;
                    end else begin
                        e_append = 1'b1;
                    end
                end
                MODE_MUST_CLOSE: begin
                    if (i_ch == w_close_ch) begin
                        e_finish = 1'b1;
                    end else begin
                        e_fail = 1'b1;
                        e_code = qet_pkg::ERR_OPEN_QUOTE;
                    end
                end
                default: begin
                end
            endcase
        end

        if (e_append) begin
            n_esc = 1'b0;
            n_len = w_len_base + 1'b1;
            if (w_cap_reach) begin
                if (e_plain_ctx) begin
                    e_finish = 1'b1;
                end else begin
                    n_mode = MODE_MUST_CLOSE;
                end
            end
        end
        if (e_finish) begin
            n_count = r_count + 8'd1;
            n_len   = '0;
            n_esc   = 1'b0;
            n_mode  = MODE_BETWEEN;
        end
        if (e_fail) begin
            n_esc  = 1'b0;
            n_mode = MODE_DISCARD;
        end
        if (i_is_end) begin
            n_mode  = MODE_BETWEEN;
            n_qd    = 1'b0;
            n_esc   = 1'b0;
            n_len   = '0;
            n_count = 8'd0;
        end

        // results in the order they are produced
        if (e_append) begin
            w_run.res[k] = '{qet_pkg::KIND_BYTE, e_byte, r_count, 1'b0};
            k = k + 2'd1;
        end
        if (e_finish) begin
            w_run.res[k] = '{qet_pkg::KIND_END, 8'd0, r_count, 1'b0};
            k = k + 2'd1;
        end
        if (e_fail) begin
            w_run.res[k] = '{qet_pkg::KIND_ERROR, 8'd0, r_count, e_code};
            k = k + 2'd1;
        end
        if (e_done) begin
            w_run.res[k] = '{qet_pkg::KIND_DONE, 8'd0, r_count + {7'd0, e_finish}, 1'b0};
            k = k + 2'd1;
        end
        w_run.count = k;
    end

    assign o_push = w_accept && (w_run.count != 2'd0);
    assign o_run  = w_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_BETWEEN;
            r_qd         <= 1'b0;
            r_esc        <= 1'b0;
            r_len        <= '0;
            r_count      <= 8'd0;
            r_max_tokens <= qet_pkg::MAX_TOKENS_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_tokens <= i_cfg_data;
            end
            if (w_accept) begin
                r_mode  <= n_mode;
                r_qd    <= n_qd;
                r_esc   <= n_esc;
                r_len   <= n_len;
                r_count <= n_count;
            end
        end
    end

endmodule

/* rtl/core/qet_queue.sv */
module qet_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qet_pkg::t_run i_run,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output qet_pkg::t_run o_head
);

    localparam int DEPTH = qet_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    qet_pkg::t_run    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_fill;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_fill == CNT_FULL);
    assign o_valid = (r_fill != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

/* rtl/core/qet_back.sv */
module qet_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  qet_pkg::t_run i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_kind,
    output logic [7:0]    o_token_byte,
    output logic [7:0]    o_token_number,
    output logic          o_error_code,
    output logic          o_last_of_run
);

    logic             r_valid;
    logic [1:0]       r_idx;
    qet_pkg::t_result r_res;
    logic             r_last;

    logic             w_advance;
    logic             w_last;

    // output register is free when empty or being taken this cycle
    assign w_advance = i_q_valid && (!r_valid || i_ready);
    assign w_last    = (r_idx == (i_head.count - 2'd1));
    assign o_pop     = w_advance && w_last;

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res  <= i_head.res[r_idx];
            r_last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (w_advance) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_res.kind;
    assign o_token_byte   = r_res.token_byte;
    assign o_token_number = r_res.token_number;
    assign o_error_code   = r_res.error_code;
    assign o_last_of_run  = r_last;

endmodule

/* rtl/core/quoted_escape_tokenizer_core.sv */
// Splits a line, fed one byte per transaction and closed by an end marker,
// into whitespace-separated tokens with single/double quoting and backslash
// escapes. A byte is taken every cycle while the four-entry result queue has
// room; each byte yields zero to three results (token byte, token end, line
// done or error), and the output side drains one result per cycle unless
// stalled, so the sustained rate is one byte per cycle for ordinary text and
// slows when a byte causes several results. The front stage classifies a
// byte and updates the scan state in the cycle it is accepted; a queued
// result enters the output register when free. max_tokens may be written at
// any time the block is idle; no clearing pass is needed after reset.
module quoted_escape_tokenizer_core #(
    parameter int TOKEN_CAP        = qet_pkg::TOKEN_CAP_DEFAULT,
    parameter int MAX_TOKENS_LIMIT = qet_pkg::MAX_TOKENS_LIMIT_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic       i_is_end,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_token_byte,
    output logic [7:0] o_token_number,
    output logic       o_error_code,
    output logic       o_last_of_run
);

    logic          w_push;
    logic          w_q_full;
    logic          w_q_valid;
    logic          w_pop;
    qet_pkg::t_run w_push_run;
    qet_pkg::t_run w_head_run;

    qet_front #(
        .TOKEN_CAP        (TOKEN_CAP),
        .MAX_TOKENS_LIMIT (MAX_TOKENS_LIMIT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_ch        (i_ch),
        .i_is_end    (i_is_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_run       (w_push_run)
    );

    qet_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_run   (w_push_run),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head_run)
    );

    qet_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_head         (w_head_run),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_token_byte   (o_token_byte),
        .o_token_number (o_token_number),
        .o_error_code   (o_error_code),
        .o_last_of_run  (o_last_of_run)
    );

`ifndef SYNTHESIS
    // line done and error always close the run of their transaction
    a_terminal_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == qet_pkg::KIND_DONE || o_kind == qet_pkg::KIND_ERROR)
        |-> o_last_of_run)
        else $error("terminal result not marked last");

    a_unused_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != qet_pkg::KIND_BYTE |-> o_token_byte == 8'd0)
        else $error("token byte set on a non-byte result");

    a_code_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != qet_pkg::KIND_ERROR |-> !o_error_code)
        else $error("error code set on a non-error result");

    // a queued run must reach the output register as soon as it is free
    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid && (!o_valid || i_ready) |=> o_valid)
        else $error("queued result not moved to output");
`endif

endmodule
